// File: sv/sab_pkg.sv
// Shared types and constants of the sprite alpha blender.
package sab_pkg;

   localparam int SPRITE_AW      = 16;                 // sprite memory address width
   localparam int SPRITE_DEPTH   = 1 << SPRITE_AW;     // sprite memory entries
   localparam int MAX_SCREEN_DIM = 2048;
   localparam int DIM_W          = 12;                 // width of screen size registers
   localparam int CNT_W          = 11;                 // width of the column and row counters
   localparam int OFS_W          = 13;                 // signed screen-to-sprite offset
   localparam int SPR_W          = 9;                  // sprite size and in-sprite offset
   localparam int IDX_W          = 2 * SPR_W;          // full lookup index before range check
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_BLEND = 1'b1;

   typedef struct packed {
      logic        command;
      logic [15:0] sprite_address;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [7:0]  alpha_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic signed [DIM_W-1:0] sprite_x;
      logic signed [DIM_W-1:0] sprite_y;
      logic [SPR_W-1:0]        sprite_width;
      logic [SPR_W-1:0]        sprite_height;
      logic [DIM_W-1:0]        screen_width;
      logic [DIM_W-1:0]        screen_height;
   } cfg_type;

   // Request as it enters the sprite memory stage.
   typedef struct packed {
      logic                 valid;
      logic                 command;
      logic [SPRITE_AW-1:0] mem_addr;
      logic                 hit;
      pixel_type            pixel;
      logic                 eof;
   } mem_stage_type;

   // Blend request leaving the memory stage; the sprite pixel travels beside it.
   typedef struct packed {
      logic      valid;
      logic      hit;
      pixel_type background;
      logic      eof;
   } blend_stage_type;

endpackage

// File: sv/sab_locate.sv
// Screen position counters and sprite lookup address generation.
module sab_locate (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   accept,
   input  sab_pkg::req_type       req,
   input  sab_pkg::cfg_type       cfg,
   output sab_pkg::mem_stage_type mem_stage
);

   typedef struct packed {
      logic                        valid;
      logic                        command;
      logic [15:0]                 sprite_address;
      logic                        in_sprite;
      logic [sab_pkg::SPR_W-1:0]   dx;
      logic [sab_pkg::SPR_W-1:0]   dy;
      sab_pkg::pixel_type          pixel;
      logic                        eof;
   } locate_type;

   logic [sab_pkg::CNT_W-1:0]        column_ff, column_in;
   logic [sab_pkg::CNT_W-1:0]        row_ff, row_in;
   locate_type                       loc_ff, loc_in;
   sab_pkg::mem_stage_type           mem_ff, mem_in;

   logic [sab_pkg::DIM_W-1:0]        width_eff, height_eff;
   logic [sab_pkg::DIM_W-1:0]        column_next, row_next;
   logic                             last_col, last_row;
   logic signed [sab_pkg::OFS_W-1:0] dx_full, dy_full;
   logic                             inside_x, inside_y;
   logic [sab_pkg::IDX_W-1:0]        index;

   // Screen sizes saturate into 1..MAX_SCREEN_DIM.
   always_comb begin
      if (cfg.screen_width == '0) begin
         width_eff = sab_pkg::DIM_W'(1);
      end else if (cfg.screen_width > sab_pkg::DIM_W'(sab_pkg::MAX_SCREEN_DIM)) begin
         width_eff = sab_pkg::DIM_W'(sab_pkg::MAX_SCREEN_DIM);
      end else begin
         width_eff = cfg.screen_width;
      end
      if (cfg.screen_height == '0) begin
         height_eff = sab_pkg::DIM_W'(1);
      end else if (cfg.screen_height > sab_pkg::DIM_W'(sab_pkg::MAX_SCREEN_DIM)) begin
         height_eff = sab_pkg::DIM_W'(sab_pkg::MAX_SCREEN_DIM);
      end else begin
         height_eff = cfg.screen_height;
      end
   end

   assign column_next = {1'b0, column_ff} + sab_pkg::DIM_W'(1);
   assign row_next    = {1'b0, row_ff} + sab_pkg::DIM_W'(1);
   assign last_col    = column_next >= width_eff;
   assign last_row    = row_next >= height_eff;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept && req.command == sab_pkg::CMD_BLEND) begin
         if (last_col) begin
            column_in = '0;
            row_in    = last_row ? '0 : row_next[sab_pkg::CNT_W-1:0];
         end else begin
            column_in = column_next[sab_pkg::CNT_W-1:0];
         end
      end
   end

   // Offset into the sprite; a negative offset or one at or past the size is outside.
   assign dx_full  = $signed({2'b00, column_ff}) - sab_pkg::OFS_W'(cfg.sprite_x);
   assign dy_full  = $signed({2'b00, row_ff}) - sab_pkg::OFS_W'(cfg.sprite_y);
   assign inside_x = !dx_full[sab_pkg::OFS_W-1] &&
                     (dx_full[sab_pkg::OFS_W-2:0] <
                      (sab_pkg::OFS_W-1)'(cfg.sprite_width));
   assign inside_y = !dy_full[sab_pkg::OFS_W-1] &&
                     (dy_full[sab_pkg::OFS_W-2:0] <
                      (sab_pkg::OFS_W-1)'(cfg.sprite_height));

   always_comb begin
      loc_in.valid          = accept;
      loc_in.command        = req.command;
      loc_in.sprite_address = req.sprite_address;
      loc_in.in_sprite      = inside_x && inside_y;
      loc_in.dx             = dx_full[sab_pkg::SPR_W-1:0];
      loc_in.dy             = dy_full[sab_pkg::SPR_W-1:0];
      loc_in.pixel          = {req.alpha_in, req.blue_in, req.green_in, req.red_in};
      loc_in.eof            = last_col && last_row;
   end

   // Row-major index into the sprite memory; anything past the memory is outside.
   assign index = sab_pkg::IDX_W'(loc_ff.dy) * sab_pkg::IDX_W'(cfg.sprite_width) +
                  sab_pkg::IDX_W'(loc_ff.dx);

   always_comb begin
      mem_in.valid    = loc_ff.valid;
      mem_in.command  = loc_ff.command;
      mem_in.hit      = loc_ff.in_sprite &&
                        (index[sab_pkg::IDX_W-1:sab_pkg::SPRITE_AW] == '0);
      mem_in.mem_addr = (loc_ff.command == sab_pkg::CMD_BLEND) ?
                        index[sab_pkg::SPRITE_AW-1:0] :
                        loc_ff.sprite_address[sab_pkg::SPRITE_AW-1:0];
      mem_in.pixel    = loc_ff.pixel;
      mem_in.eof      = loc_ff.eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         loc_ff.valid <= 1'b0;
         mem_ff.valid <= 1'b0;
      end else if (en) begin
         column_ff <= column_in;
         row_ff    <= row_in;
         loc_ff    <= loc_in;
         mem_ff    <= mem_in;
      end
   end

   assign mem_stage = mem_ff;

endmodule

// File: sv/sab_sprite_mem.sv
// Sprite pixel memory: one write or one registered read per request.
module sab_sprite_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  sab_pkg::mem_stage_type   mem_stage,
   output sab_pkg::blend_stage_type blend_stage,
   output sab_pkg::pixel_type       sprite_pixel
);

   sab_pkg::pixel_type       mem [sab_pkg::SPRITE_DEPTH];
   sab_pkg::pixel_type       rd_ff;
   sab_pkg::blend_stage_type blend_ff, blend_in;

   // Accesses happen in request order, so a blend sees every earlier write.
   always_ff @(posedge clock) begin
      if (en) begin
         if (mem_stage.valid && mem_stage.command == sab_pkg::CMD_WRITE) begin
            mem[mem_stage.mem_addr] <= mem_stage.pixel;
         end
         rd_ff <= mem[mem_stage.mem_addr];
      end
   end

   always_comb begin
      blend_in.valid      = mem_stage.valid && mem_stage.command == sab_pkg::CMD_BLEND;
      blend_in.hit        = mem_stage.hit;
      blend_in.background = mem_stage.pixel;
      blend_in.eof        = mem_stage.eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff.valid <= 1'b0;
      end else if (en) begin
         blend_ff <= blend_in;
      end
   end

   assign blend_stage  = blend_ff;
   assign sprite_pixel = rd_ff;

endmodule

// File: sv/sab_mix.sv
// Per-channel blend arithmetic and the response register.
module sab_mix (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  sab_pkg::blend_stage_type blend_stage,
   input  sab_pkg::pixel_type       sprite_pixel,
   output logic                     rsp_valid,
   output sab_pkg::rsp_type         rsp_payload
);

   typedef struct packed {
      logic             valid;
      logic             eof;
      logic [3:0][15:0] sum;
   } sum_type;

   sum_type            sum_ff, sum_in;
   logic               rsp_valid_ff;
   sab_pkg::rsp_type   rsp_ff, rsp_in;
   sab_pkg::pixel_type spr;

   function automatic logic [15:0] weigh(input logic [7:0] s, input logic [7:0] b,
                                         input logic [7:0] sa);
      logic [15:0] ps;
      logic [15:0] pb;
      begin
         ps    = s * sa;
         pb    = b * (8'd255 - sa);
         weigh = ps + pb;
      end
   endfunction

   // Exact floor(x / 255) for any x up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      begin
         t      = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
         div255 = t[15:8];
      end
   endfunction

   // A lookup outside the sprite acts as a fully transparent pixel.
   assign spr = blend_stage.hit ? sprite_pixel : '0;

   always_comb begin
      sum_in.valid  = blend_stage.valid;
      sum_in.eof    = blend_stage.eof;
      sum_in.sum[0] = weigh(spr.red,   blend_stage.background.red,   spr.alpha);
      sum_in.sum[1] = weigh(spr.green, blend_stage.background.green, spr.alpha);
      sum_in.sum[2] = weigh(spr.blue,  blend_stage.background.blue,  spr.alpha);
      sum_in.sum[3] = weigh(spr.alpha, blend_stage.background.alpha, spr.alpha);
   end

   always_comb begin
      rsp_in.red_out      = div255(sum_ff.sum[0]);
      rsp_in.green_out    = div255(sum_ff.sum[1]);
      rsp_in.blue_out     = div255(sum_ff.sum[2]);
      rsp_in.alpha_out    = div255(sum_ff.sum[3]);
      rsp_in.end_of_frame = sum_ff.eof;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= sum_ff.valid;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: sv/sprite_alpha_blender.sv
// Top level of the sprite alpha blender: configuration registers and pipeline control.
//
// The blender takes one request per clock. A write request stores one RGBA pixel into the
// 65536-entry sprite memory at sprite_address and gives no response. A blend request carries
// one background pixel in raster order; the block tracks the screen column and row itself,
// fetches the sprite pixel at (column - sprite_x, row - sprite_y), treats any position
// outside the sprite or past the memory as transparent, and returns each channel as
// (s*sa + b*(255-sa))/255, alpha included, with end_of_frame set on the last pixel of the
// screen. Throughput is one request per cycle while no stall holds it; each response
// comes out of the five-stage pipeline (offset, index multiply, memory read, channel
// products, divide and response register). All stages advance together, so the block
// stalls requests only while a response waits and rsp_stall is high. Memory writes and
// reads happen in the same stage, in request order, so a blend always sees every write
// accepted before it. Sprite memory content is undefined until written, and
// configuration registers should only be written while no request is in flight.
module sprite_alpha_blender (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  sab_pkg::req_type                   req_payload,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sab_pkg::rsp_type                   rsp_payload,

   input  logic                               csr_write_enable,
   input  logic [sab_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sab_pkg::CSR_DATA_W-1:0]     csr_data
);

   sab_pkg::cfg_type         cfg_ff, cfg_in;
   sab_pkg::mem_stage_type   mem_stage;
   sab_pkg::blend_stage_type blend_stage;
   sab_pkg::pixel_type       sprite_pixel;
   logic                     en;
   logic                     accept;

   // The whole pipeline moves unless a finished response is being held back.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // Register writes keep only the low bits that each register holds.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sab_pkg::CSR_SPRITE_X:      cfg_in.sprite_x      = csr_data;
            sab_pkg::CSR_SPRITE_Y:      cfg_in.sprite_y      = csr_data;
            sab_pkg::CSR_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_data[sab_pkg::SPR_W-1:0];
            sab_pkg::CSR_SPRITE_HEIGHT: cfg_in.sprite_height = csr_data[sab_pkg::SPR_W-1:0];
            sab_pkg::CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_data;
            sab_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sprite_x      <= '0;
         cfg_ff.sprite_y      <= '0;
         cfg_ff.sprite_width  <= sab_pkg::SPR_W'(256);
         cfg_ff.sprite_height <= sab_pkg::SPR_W'(256);
         cfg_ff.screen_width  <= sab_pkg::DIM_W'(800);
         cfg_ff.screen_height <= sab_pkg::DIM_W'(600);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sab_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .accept    (accept),
      .req       (req_payload),
      .cfg       (cfg_ff),
      .mem_stage (mem_stage)
   );

   sab_sprite_mem u_sprite_mem (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .mem_stage    (mem_stage),
      .blend_stage  (blend_stage),
      .sprite_pixel (sprite_pixel)
   );

   sab_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .blend_stage  (blend_stage),
      .sprite_pixel (sprite_pixel),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the sprite alpha blender: directed table, then random phases.
module testbench;

   // Cycles to let the pipeline empty after the last expected response before the
   // registers change; sprite writes give no response and may still be in flight.
   localparam int SETTLE_CYCLES = 12;
   // Length of the one long receiver hold-off that makes the block back up.
   localparam int HOLD_CYCLES   = 300;
   localparam int NUM_PHASES    = 9;
   localparam int PHASE_ITEMS   = 95;
   localparam int MAX_REPORTS   = 10;

   typedef enum {ROW_REQUEST, ROW_REGISTERS} row_kind_type;

   // One line of the directed table: either a request or a full register setting.
   // Where typed is set, typed_rsp is the response read straight off the row and it
   // replaces the predicted one in the queue of expected pixels.
   typedef struct {
      row_kind_type     kind;
      sab_pkg::req_type request;
      bit               typed;
      sab_pkg::rsp_type typed_rsp;
      sab_pkg::cfg_type regs;
   } stim_row_type;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_stall;
   sab_pkg::req_type               req_payload      = '0;
   logic                           rsp_valid;
   logic                           rsp_stall        = 1'b0;
   sab_pkg::rsp_type               rsp_payload;
   logic                           csr_write_enable = 1'b0;
   logic [sab_pkg::CSR_IDX_W-1:0]  csr_index        = sab_pkg::CSR_SPRITE_X;
   logic [sab_pkg::CSR_DATA_W-1:0] csr_data         = '0;

   sprite_alpha_blender dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Shadow of the block: register values, screen position and sprite memory.
   sab_pkg::cfg_type          active_regs;
   sab_pkg::pixel_type        sprite_mem [sab_pkg::SPRITE_DEPTH];
   bit                        mem_written [sab_pkg::SPRITE_DEPTH];
   logic [sab_pkg::CNT_W-1:0] screen_col;
   logic [sab_pkg::CNT_W-1:0] screen_row;
   sab_pkg::rsp_type          expected_pixels [$];

   int error_count    = 0;
   int requests_sent  = 0;
   int writes_sent    = 0;
   int blends_sent    = 0;
   int responses_seen = 0;
   int frames_seen    = 0;
   int settings_used  = 0;

   // When steady is set, neither side inserts random idle cycles.
   bit steady         = 1'b0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit hold_off_armed = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Screen sizes of zero count as one and sizes past the maximum saturate.
   function automatic int clamp_screen(logic [sab_pkg::DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > sab_pkg::MAX_SCREEN_DIM) return sab_pkg::MAX_SCREEN_DIM;
      return int'(v);
   endfunction

   function automatic logic [7:0] mix_channel(int s, int b, int sa);
      return 8'((s * sa + b * (255 - sa)) / 255);
   endfunction

   // Sprite memory index under the current screen position, or -1 where the
   // position falls outside the sprite or past the end of the memory.
   function automatic int sprite_index();
      int dx;
      int dy;
      int idx;
      dx = int'(screen_col) - int'($signed(active_regs.sprite_x));
      dy = int'(screen_row) - int'($signed(active_regs.sprite_y));
      if (dx < 0 || dy < 0) return -1;
      if (dx >= int'(active_regs.sprite_width) || dy >= int'(active_regs.sprite_height))
         return -1;
      idx = dy * int'(active_regs.sprite_width) + dx;
      if (idx >= sab_pkg::SPRITE_DEPTH) return -1;
      return idx;
   endfunction

   // Works out the blended pixel for one background pixel and moves the raster on.
   function automatic sab_pkg::rsp_type predict_blend(sab_pkg::req_type r);
      sab_pkg::rsp_type   res;
      sab_pkg::pixel_type spr;
      int                 idx;
      bit                 last_col;
      bit                 last_row;
      idx = sprite_index();
      spr = '0;
      if (idx >= 0) spr = sprite_mem[idx];
      res.red_out   = mix_channel(spr.red, r.red_in, spr.alpha);
      res.green_out = mix_channel(spr.green, r.green_in, spr.alpha);
      res.blue_out  = mix_channel(spr.blue, r.blue_in, spr.alpha);
      res.alpha_out = mix_channel(spr.alpha, r.alpha_in, spr.alpha);
      // A counter sitting at or past the last position wraps as if it were on it,
      // which covers a screen that shrank in the middle of a frame.
      last_col = int'(screen_col) + 1 >= clamp_screen(active_regs.screen_width);
      last_row = int'(screen_row) + 1 >= clamp_screen(active_regs.screen_height);
      res.end_of_frame = last_col && last_row;
      if (last_col) begin
         screen_col = '0;
         screen_row = last_row ? '0 : screen_row + 1'b1;
      end else begin
         screen_col = screen_col + 1'b1;
      end
      return res;
   endfunction

   function automatic sab_pkg::cfg_type make_regs(int sx, int sy, int sw, int sh, int scw,
                                                  int sch);
      sab_pkg::cfg_type regs;
      regs.sprite_x      = 12'(sx);
      regs.sprite_y      = 12'(sy);
      regs.sprite_width  = 9'(sw);
      regs.sprite_height = 9'(sh);
      regs.screen_width  = 12'(scw);
      regs.screen_height = 12'(sch);
      return regs;
   endfunction

   // Pixels are written as {red, green, blue, alpha} throughout the stimulus.
   function automatic sab_pkg::req_type make_req(logic cmd, logic [15:0] addr,
                                                 logic [31:0] rgba);
      return sab_pkg::req_type'({cmd, addr, rgba});
   endfunction

   function automatic stim_row_type request_row(sab_pkg::req_type r, bit typed,
                                                logic [31:0] want_rgba, bit eof);
      stim_row_type row;
      row.kind      = ROW_REQUEST;
      row.request   = r;
      row.typed     = typed;
      row.typed_rsp = sab_pkg::rsp_type'({want_rgba, eof});
      row.regs      = '0;
      return row;
   endfunction

   function automatic stim_row_type regs_row(sab_pkg::cfg_type regs);
      stim_row_type row;
      row.kind      = ROW_REGISTERS;
      row.request   = '0;
      row.typed     = 1'b0;
      row.typed_rsp = '0;
      row.regs      = regs;
      return row;
   endfunction

   // Offers one request and waits for the handshake. The valid stays high on return so
   // that back-to-back requests never lower and raise it within one time step; a random
   // gap, when taken, lowers it first and waits on the clock before raising it again.
   task automatic send_request(input sab_pkg::req_type r, input bit typed,
                               input sab_pkg::rsp_type typed_rsp);
      sab_pkg::rsp_type predicted;
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      requests_sent++;
      if (r.command == sab_pkg::CMD_WRITE) begin
         sprite_mem[r.sprite_address]  = {r.alpha_in, r.blue_in, r.green_in, r.red_in};
         mem_written[r.sprite_address] = 1'b1;
         writes_sent++;
      end else begin
         predicted = predict_blend(r);
         expected_pixels.push_back(typed ? typed_rsp : predicted);
         blends_sent++;
      end
   endtask

   // Sprite memory holds nothing defined until written, so a blend that would land on a
   // fresh entry is preceded by a write of random content to that entry.
   task automatic offer_request(input sab_pkg::req_type r, input bit typed,
                                input sab_pkg::rsp_type typed_rsp);
      sab_pkg::req_type fill;
      int               idx;
      if (r.command == sab_pkg::CMD_BLEND) begin
         idx = sprite_index();
         if (idx >= 0 && !mem_written[idx]) begin
            fill = make_req(sab_pkg::CMD_WRITE, 16'(idx), $urandom);
            send_request(fill, 1'b0, '0);
         end
      end
      send_request(r, typed, typed_rsp);
   endtask

   // The sender stops and waits for every outstanding response. It always waits on the clock
   // before it checks, so the lowered valid never shares a time step with a new raise.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic write_register(input logic [sab_pkg::CSR_IDX_W-1:0] index,
                                 input logic [sab_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(posedge clock);
   endtask

   // Registers change only with the pipeline empty. The bits above the sprite size fields
   // are filled at random since the block has to drop them.
   task automatic program_registers(input sab_pkg::cfg_type regs);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(sab_pkg::CSR_SPRITE_X, regs.sprite_x);
      write_register(sab_pkg::CSR_SPRITE_Y, regs.sprite_y);
      write_register(sab_pkg::CSR_SPRITE_WIDTH, {3'($urandom), regs.sprite_width});
      write_register(sab_pkg::CSR_SPRITE_HEIGHT, {3'($urandom), regs.sprite_height});
      write_register(sab_pkg::CSR_SCREEN_WIDTH, regs.screen_width);
      write_register(sab_pkg::CSR_SCREEN_HEIGHT, regs.screen_height);
      csr_write_enable <= 1'b0;
      active_regs = regs;
      settings_used++;
   endtask

   // Receiver: random stalls, none while steady, and one long hold-off on request. The
   // hold-off is counted here so the sender keeps offering requests meanwhile and the
   // block ends up stalling its input.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            hold_left      = HOLD_CYCLES;
            rsp_stall      <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 20);
         end
      end
   end

   // Response checker: each accepted response is matched against the oldest expected pixel.
   always @(posedge clock) begin
      sab_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         responses_seen++;
         if (rsp_payload.end_of_frame === 1'b1) frames_seen++;
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("Unexpected response with nothing pending: %h", rsp_payload);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.red_out !== want.red_out ||
                rsp_payload.green_out !== want.green_out ||
                rsp_payload.blue_out !== want.blue_out ||
                rsp_payload.alpha_out !== want.alpha_out ||
                rsp_payload.end_of_frame !== want.end_of_frame) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Response %0d: expected %h %h %h %h eof %b, got %h %h %h %h eof %b",
                           responses_seen, want.red_out, want.green_out, want.blue_out,
                           want.alpha_out, want.end_of_frame, rsp_payload.red_out,
                           rsp_payload.green_out, rsp_payload.blue_out,
                           rsp_payload.alpha_out, rsp_payload.end_of_frame);
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #400_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      stim_row_type     rows [$];
      sab_pkg::cfg_type regs;
      logic [15:0]      addr;
      int               phase;
      int               n;
      int               area;
      int               phase_start;
      bit               hold_done;
      bit               pause_done;

      active_regs = make_regs(0, 0, 256, 256, 800, 600);
      screen_col  = '0;
      screen_row  = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. At the reset setting the sprite sits at the origin: an opaque
      // white pixel replaces a black background, a fully transparent one passes it.
      rows.push_back(request_row(make_req(sab_pkg::CMD_WRITE, 16'h0000, 32'hffffffff),
                                 0, 0, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_WRITE, 16'h0001, 32'h12345600),
                                 0, 0, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h00000000), 1,
                                 32'hffffffff, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'hffff, 32'habcdef01), 1,
                                 32'habcdef01, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_WRITE, 16'hffff, 32'h807f01fe),
                                 0, 0, 0));
      // Zero sprite size, extreme positions, and a screen of zero width that clamps to one
      // column while the column counter already sits past it.
      rows.push_back(regs_row(make_regs(-2048, 2047, 0, 0, 0, 4095)));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'hffffffff), 1,
                                 32'hffffffff, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h00000000), 1,
                                 32'h00000000, 0));
      // Widest sprite far above the screen: the lookup index runs past the memory, so the
      // background passes. The row counter starts past a one-row screen.
      rows.push_back(regs_row(make_regs(0, -200, 511, 511, 2, 1)));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h5a5a5a5a), 1,
                                 32'h5a5a5a5a, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'ha5c3e718), 1,
                                 32'ha5c3e718, 1));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h00ff00ff), 1,
                                 32'h00ff00ff, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'hff00ff00), 1,
                                 32'hff00ff00, 1));
      // Two-pixel sprite in the lower right of a 4x2 screen: the first row sees a negative
      // row offset, the start of the second row a negative column offset, then a
      // half-transparent pixel and an opaque one on the last pixel of the frame.
      rows.push_back(regs_row(make_regs(2, 1, 2, 1, 4, 2)));
      rows.push_back(request_row(make_req(sab_pkg::CMD_WRITE, 16'h0000, 32'h4080c080),
                                 0, 0, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_WRITE, 16'h0001, 32'h010203ff),
                                 0, 0, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h11223344), 1,
                                 32'h11223344, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h55667788), 1,
                                 32'h55667788, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h99aabbcc), 1,
                                 32'h99aabbcc, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'hddeeff00), 1,
                                 32'hddeeff00, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h13579bdf), 1,
                                 32'h13579bdf, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h2468ace0), 1,
                                 32'h2468ace0, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'h80808080),
                                 0, 0, 0));
      rows.push_back(request_row(make_req(sab_pkg::CMD_BLEND, 16'h0000, 32'hfedcba98), 1,
                                 32'h010203ff, 1));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_REGISTERS) begin
            program_registers(rows[i].regs);
         end else begin
            offer_request(rows[i].request, rows[i].typed, rows[i].typed_rsp);
         end
      end

      // Random part, one register setting per phase. Most settings keep the screen and the
      // sprite small so frames end often; a few take the extremes, one is fully random.
      // Each phase sends at least PHASE_ITEMS requests, fill writes included.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         unique case (phase)
            0: regs = make_regs(2047, -2048, 511, 511, 4095, 4095);
            1: regs = sab_pkg::cfg_type'({12'($urandom), 12'($urandom), 9'($urandom),
                                          9'($urandom), 12'($urandom), 12'($urandom)});
            2: regs = make_regs(0, 0, 1, 1, 1, 1);
            3: regs = make_regs(0, 0, 256, 256, 2048, 2);
            4: regs = make_regs(-1, -1, 3, 2, 0, 3);
            default: regs = make_regs($urandom_range(0, 28) - 4, $urandom_range(0, 12) - 4,
                                      $urandom_range(0, 10), $urandom_range(0, 6),
                                      $urandom_range(1, 24), $urandom_range(1, 8));
         endcase
         // One whole phase runs with no idle cycles on either side.
         steady = (phase == 6);
         program_registers(regs);
         area        = int'(regs.sprite_width) * int'(regs.sprite_height);
         phase_start = requests_sent;
         hold_done   = 1'b0;
         pause_done  = 1'b0;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            n = requests_sent - phase_start;
            if (phase == 5 && n >= 20 && !hold_done) begin
               hold_off_armed = 1'b1;
               hold_done      = 1'b1;
            end
            if (phase == 5 && n >= 60 && !pause_done) begin
               wait_drained();
               pause_done = 1'b1;
            end
            if ($urandom_range(99) < 15) begin
               // With a non-empty sprite, half of the writes update pixels inside it, the rest go anywhere.
               if (area > 0 && $urandom_range(1) == 1)
                  addr = 16'($urandom_range(0, (area > sab_pkg::SPRITE_DEPTH ?
                                                sab_pkg::SPRITE_DEPTH : area) - 1));
               else
                  addr = 16'($urandom);
               offer_request(make_req(sab_pkg::CMD_WRITE, addr, $urandom), 1'b0, '0);
            end else begin
               offer_request(make_req(sab_pkg::CMD_BLEND, 16'($urandom), $urandom), 1'b0,
                             '0);
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         error_count++;
         $display("%0d expected pixels never arrived", expected_pixels.size());
      end

      $display("Sent %0d requests (%0d sprite writes, %0d blends); checked %0d responses.",
               requests_sent, writes_sent, blends_sent, responses_seen);
      $display("Saw %0d frame ends over %0d register settings, extremes to tiny screens.",
               frames_seen, settings_used);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
sv/sab_pkg.sv
sv/sab_locate.sv
sv/sab_sprite_mem.sv
sv/sab_mix.sv
sv/sprite_alpha_blender.sv
sim/testbench.sv
